// ----- rtl/ttrr_pkg.sv -----
// ttrr_pkg: shared types and codes for the task table scheduler
// no dependencies
`default_nettype none
package ttrr_pkg;

    typedef enum logic [3:0] {
        FN_ALLOC    = 4'd0,
        FN_FREE     = 4'd1,
        FN_READY    = 4'd2,
        FN_YIELD    = 4'd3,
        FN_BLOCK    = 4'd4,
        FN_LINK     = 4'd5,
        FN_EXIT     = 4'd6,
        FN_FINDZ    = 4'd7,
        FN_SCHEDULE = 4'd8,
        FN_RUN      = 4'd9
    } func_t;

    localparam logic [2:0] ST_UNUSED  = 3'd0;
    localparam logic [2:0] ST_UNINIT  = 3'd1;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_RUNNING = 3'd3;
    localparam logic [2:0] ST_BLOCKED = 3'd4;
    localparam logic [2:0] ST_ZOMBIE  = 3'd5;

    typedef struct packed {
        logic [3:0]  func;
        logic [5:0]  slot;
        logic signed [31:0] exit_value;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  result_slot;
        logic [31:0] result_pid;
        logic signed [31:0] result_exit;
        logic [2:0]  result_status;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item
        logic scan_clr; // zero scan index
        logic scan_inc; // advance scan index
        logic apply;    // perform single-step op
        logic hit_act;  // act on scan hit
        logic fail;     // report failure
        logic clr_link; // clear matching link at scan index
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       scan_last;
        logic       scan_hit;
        logic [3:0] func;
        logic       slot_ok;
    } ctl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/ttrr_dpath.sv -----
// ttrr_dpath: task table storage, scan index and result register
// depends on ttrr_pkg
`default_nettype none
module ttrr_dpath #(
    parameter int SLOTS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ttrr_pkg::in_item_t   in_item,
    input  wire ttrr_pkg::ctl_cmd_t   cmd,
    output ttrr_pkg::ctl_sts_t        sts,
    output ttrr_pkg::out_item_t       res
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

    logic [2:0]    status_reg [SLOTS];
    logic [31:0]   pid_mem [SLOTS];
    logic          pid_vld_reg [SLOTS];
    logic [LW-1:0] link_reg [SLOTS];
    logic [7:0]    count_reg [SLOTS];
    logic [31:0]   exit_mem [SLOTS];
    logic [31:0]   pidc_reg;
    logic [IW-1:0] cur_reg;
    ttrr_pkg::in_item_t op_reg;
    logic [IW:0]   idx_reg;
    ttrr_pkg::out_item_t res_reg;

    logic [IW-1:0] scan_pos;
    logic [IW-1:0] tgt;
    logic [IW-1:0] sched_pos;
    logic [IW:0]   sum;
    logic          slot_ok;
    logic          hit;

    assign slot_ok = ({3'b0, op_reg.slot} < 9'(SLOTS));
    assign tgt = (op_reg.func == ttrr_pkg::FN_YIELD || op_reg.func == ttrr_pkg::FN_BLOCK)
                 ? cur_reg : IW'(op_reg.slot);
    assign sum = {1'b0, cur_reg} + idx_reg + (IW+1)'(1);
    assign sched_pos = (sum >= (IW+1)'(SLOTS)) ? IW'(sum - (IW+1)'(SLOTS)) : sum[IW-1:0];
    assign scan_pos = (op_reg.func == ttrr_pkg::FN_SCHEDULE) ? sched_pos : idx_reg[IW-1:0];

    always_comb
    begin
        unique case (op_reg.func)
            ttrr_pkg::FN_ALLOC:
                hit = (scan_pos != '0) && status_reg[scan_pos] == ttrr_pkg::ST_UNUSED;
            ttrr_pkg::FN_FREE:
                hit = status_reg[tgt] == ttrr_pkg::ST_RUNNING;
            ttrr_pkg::FN_FINDZ:
                hit = link_reg[scan_pos] == LW'(op_reg.slot)
                      && status_reg[scan_pos] == ttrr_pkg::ST_ZOMBIE;
            ttrr_pkg::FN_SCHEDULE:
                hit = status_reg[scan_pos] == ttrr_pkg::ST_READY;
            default:
                hit = 1'b0;
        endcase
    end

    assign sts.scan_last = (idx_reg == (IW+1)'(SLOTS - 1));
    assign sts.scan_hit  = hit;
    assign sts.func      = op_reg.func;
    assign sts.slot_ok   = slot_ok;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i]  <= (i == 0) ? ttrr_pkg::ST_RUNNING : ttrr_pkg::ST_UNUSED;
                pid_vld_reg[i] <= 1'b0;
                link_reg[i]    <= LINK_NONE;
                count_reg[i]   <= '0;
            end
            pidc_reg <= 32'd1;
            cur_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.scan_clr)
                idx_reg <= '0;
            else if (cmd.scan_inc)
                idx_reg <= idx_reg + (IW+1)'(1);
            if (cmd.clr_link && link_reg[idx_reg[IW-1:0]] == LW'(op_reg.slot))
                link_reg[idx_reg[IW-1:0]] <= LINK_NONE;
            if (cmd.apply)
            begin
                unique case (op_reg.func)
                    ttrr_pkg::FN_FREE:  status_reg[tgt] <= ttrr_pkg::ST_UNUSED;
                    ttrr_pkg::FN_READY,
                    ttrr_pkg::FN_YIELD: status_reg[tgt] <= ttrr_pkg::ST_READY;
                    ttrr_pkg::FN_BLOCK: status_reg[tgt] <= ttrr_pkg::ST_BLOCKED;
                    ttrr_pkg::FN_LINK:
                    begin
                        link_reg[tgt] <= LW'(cur_reg);
                        if (count_reg[cur_reg] != 8'hff)
                            count_reg[cur_reg] <= count_reg[cur_reg] + 8'd1;
                    end
                    ttrr_pkg::FN_EXIT:  status_reg[tgt] <= ttrr_pkg::ST_ZOMBIE;
                    ttrr_pkg::FN_RUN:
                    begin
                        status_reg[tgt] <= ttrr_pkg::ST_RUNNING;
                        cur_reg <= tgt;
                    end
                    default: ;
                endcase
            end
            if (cmd.hit_act)
            begin
                if (op_reg.func == ttrr_pkg::FN_ALLOC)
                begin
                    status_reg[scan_pos]  <= ttrr_pkg::ST_UNINIT;
                    pid_vld_reg[scan_pos] <= 1'b1;
                    pidc_reg              <= pidc_reg + 32'd1;
                    link_reg[scan_pos]    <= LINK_NONE;
                    count_reg[scan_pos]   <= '0;
                end
                else if (op_reg.func == ttrr_pkg::FN_SCHEDULE)
                begin
                    status_reg[scan_pos] <= ttrr_pkg::ST_RUNNING;
                    cur_reg <= scan_pos;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= in_item;
        if (cmd.hit_act && op_reg.func == ttrr_pkg::FN_ALLOC)
            pid_mem[scan_pos] <= pidc_reg;
        if (cmd.apply && op_reg.func == ttrr_pkg::FN_EXIT)
            exit_mem[tgt] <= op_reg.exit_value;
        if (cmd.fail)
            res_reg <= '0;
        else if (cmd.hit_act)
        begin
            res_reg.ok          <= 1'b1;
            res_reg.result_slot <= 6'(scan_pos);
            res_reg.result_pid  <= (op_reg.func == ttrr_pkg::FN_ALLOC) ? pidc_reg
                                   : pid_vld_reg[scan_pos] ? pid_mem[scan_pos] : '0;
            res_reg.result_exit <= (op_reg.func == ttrr_pkg::FN_FINDZ)
                                   ? exit_mem[scan_pos] : '0;
            res_reg.result_status <= (op_reg.func == ttrr_pkg::FN_ALLOC) ? ttrr_pkg::ST_UNINIT
                                   : (op_reg.func == ttrr_pkg::FN_SCHEDULE)
                                   ? ttrr_pkg::ST_RUNNING : status_reg[scan_pos];
        end
        else if (cmd.apply)
        begin
            res_reg.ok          <= 1'b1;
            res_reg.result_slot <= 6'(tgt);
            res_reg.result_pid  <= pid_vld_reg[tgt] ? pid_mem[tgt] : '0;
            res_reg.result_exit <= (op_reg.func == ttrr_pkg::FN_EXIT) ? op_reg.exit_value : '0;
            unique case (op_reg.func)
                ttrr_pkg::FN_FREE:  res_reg.result_status <= ttrr_pkg::ST_UNUSED;
                ttrr_pkg::FN_READY,
                ttrr_pkg::FN_YIELD: res_reg.result_status <= ttrr_pkg::ST_READY;
                ttrr_pkg::FN_BLOCK: res_reg.result_status <= ttrr_pkg::ST_BLOCKED;
                ttrr_pkg::FN_EXIT:  res_reg.result_status <= ttrr_pkg::ST_ZOMBIE;
                ttrr_pkg::FN_RUN:   res_reg.result_status <= ttrr_pkg::ST_RUNNING;
                default:            res_reg.result_status <= status_reg[tgt];
            endcase
        end
    end

`ifndef SYNTH
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < (IW+1)'(SLOTS)) else $error("current slot out of range");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < (IW+1)'(SLOTS)) else $error("scan index out of range");
    a_pid_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit_act && op_reg.func == ttrr_pkg::FN_ALLOC |=> pidc_reg == $past(pidc_reg) + 32'd1)
        else $error("pid counter did not advance");
    a_one_act: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.apply, cmd.hit_act, cmd.fail})) else $error("conflicting commands");
`endif
endmodule
`default_nettype wire

// ----- rtl/ttrr_ctrl.sv -----
// ttrr_ctrl: sequencing state machine for the task table scheduler
// depends on ttrr_pkg
`default_nettype none
module ttrr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire ttrr_pkg::ctl_sts_t sts,
    output ttrr_pkg::ctl_cmd_t      cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_SCAN = 5'b00100,
        S_CLR  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic in_xfer;
    logic out_xfer;
    logic is_scan;
    logic needs_slot;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign is_scan = (sts.func == ttrr_pkg::FN_ALLOC) || (sts.func == ttrr_pkg::FN_FINDZ)
                     || (sts.func == ttrr_pkg::FN_SCHEDULE);
    assign needs_slot = (sts.func == ttrr_pkg::FN_FREE) || (sts.func == ttrr_pkg::FN_READY)
                     || (sts.func == ttrr_pkg::FN_LINK) || (sts.func == ttrr_pkg::FN_EXIT)
                     || (sts.func == ttrr_pkg::FN_FINDZ) || (sts.func == ttrr_pkg::FN_RUN);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_xfer;
                cmd.scan_clr = 1'b1;
                if (in_xfer)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.func > ttrr_pkg::FN_RUN || (needs_slot && !sts.slot_ok))
                begin
                    cmd.fail = 1'b1;
                    state_next = S_OUT;
                end
                else if (is_scan)
                    state_next = S_SCAN;
                else if (sts.func == ttrr_pkg::FN_FREE && sts.scan_hit)
                begin
                    cmd.fail = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    state_next = (sts.func == ttrr_pkg::FN_EXIT) ? S_CLR : S_OUT;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.hit_act = 1'b1;
                    state_next = S_OUT;
                end
                else if (sts.scan_last)
                begin
                    cmd.fail = 1'b1;
                    state_next = S_OUT;
                end
                else
                    cmd.scan_inc = 1'b1;
            end
            S_CLR:
            begin
                cmd.clr_link = 1'b1;
                if (sts.scan_last)
                    state_next = S_OUT;
                else
                    cmd.scan_inc = 1'b1;
            end
            S_OUT:
            begin
                if (out_xfer)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !cmd.load) else $error("transfer taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_dec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DEC) else $error("load not followed by decode");
`endif
endmodule
`default_nettype wire

// ----- rtl/task_table_round_robin_scheduler.sv -----
// task_table_round_robin_scheduler: top level of the task table scheduler
// depends on ttrr_pkg, ttrr_ctrl, ttrr_dpath
`default_nettype none
// One operation at a time. Ready, free, yield, block, fork-link and run give
// their result without a scan; alloc, findzombie and schedule scan the table
// one slot a cycle, and exit clears child links one slot a cycle over every
// slot. After the result transfer the block returns to idle before it takes
// the next input transfer. A schedule with nothing ready returns ok low.
module task_table_round_robin_scheduler #(
    parameter int SLOTS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ttrr_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ttrr_pkg::out_item_t      out_data
);
    ttrr_pkg::ctl_cmd_t cmd;
    ttrr_pkg::ctl_sts_t sts;
    ttrr_pkg::out_item_t res;

    ttrr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .sts(sts), .cmd(cmd)
    );

    ttrr_dpath #(.SLOTS(SLOTS)) u_dpath (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_data), .cmd(cmd), .sts(sts), .res(res)
    );

    assign out_data = res;
endmodule
`default_nettype wire

// ----- test/tb_task_table_round_robin_scheduler.sv -----
// testbench for task_table_round_robin_scheduler: random and directed task table operations
// checked against a local task table predictor; depends on ttrr_pkg and the rtl
`timescale 1ns / 1ps

class task_scoreboard;
    ttrr_pkg::out_item_t pending_q[$];
    logic [2:0]  status_tab[64];
    logic [31:0] pid_tab[64];
    logic [6:0]  parent_tab[64];
    logic [7:0]  kids_tab[64];
    logic [31:0] exit_tab[64];
    logic [31:0] pid_seq;
    logic [5:0]  cur;
    int errors;

    function new();
        for (int i = 0; i < 64; i++)
        begin
            status_tab[i] = ttrr_pkg::ST_UNUSED;
            pid_tab[i] = 0;
            parent_tab[i] = 7'd64;
            kids_tab[i] = 0;
            exit_tab[i] = 0;
        end
        status_tab[0] = ttrr_pkg::ST_RUNNING;
        pid_seq = 1;
        cur = 0;
        errors = 0;
    endfunction

    function ttrr_pkg::out_item_t hit(int s, bit with_exit);
        ttrr_pkg::out_item_t r;
        r.ok = 1'b1;
        r.result_slot = s[5:0];
        r.result_pid = pid_tab[s];
        r.result_exit = with_exit ? exit_tab[s] : 32'd0;
        r.result_status = status_tab[s];
        return r;
    endfunction

    function void note_transfer(ttrr_pkg::in_item_t it);
        ttrr_pkg::out_item_t r;
        int s;
        int idx;
        r = '0;
        s = it.slot;
        case (it.func)
            ttrr_pkg::FN_ALLOC:
                for (int i = 1; i < 64; i++)
                    if (status_tab[i] == ttrr_pkg::ST_UNUSED)
                    begin
                        pid_tab[i] = pid_seq;
                        pid_seq = pid_seq + 1;
                        status_tab[i] = ttrr_pkg::ST_UNINIT;
                        parent_tab[i] = 7'd64;
                        kids_tab[i] = 0;
                        r = hit(i, 0);
                        break;
                    end
            ttrr_pkg::FN_FREE:
                if (status_tab[s] != ttrr_pkg::ST_RUNNING)
                begin
                    status_tab[s] = ttrr_pkg::ST_UNUSED;
                    r = hit(s, 0);
                end
            ttrr_pkg::FN_READY:
            begin
                status_tab[s] = ttrr_pkg::ST_READY;
                r = hit(s, 0);
            end
            ttrr_pkg::FN_YIELD:
            begin
                status_tab[cur] = ttrr_pkg::ST_READY;
                r = hit(cur, 0);
            end
            ttrr_pkg::FN_BLOCK:
            begin
                status_tab[cur] = ttrr_pkg::ST_BLOCKED;
                r = hit(cur, 0);
            end
            ttrr_pkg::FN_LINK:
            begin
                parent_tab[s] = {1'b0, cur};
                if (kids_tab[cur] != 8'd255)
                    kids_tab[cur]++;
                r = hit(s, 0);
            end
            ttrr_pkg::FN_EXIT:
            begin
                status_tab[s] = ttrr_pkg::ST_ZOMBIE;
                exit_tab[s] = it.exit_value;
                for (int i = 0; i < 64; i++)
                    if (parent_tab[i] == s)
                        parent_tab[i] = 7'd64;
                r = hit(s, 1);
            end
            ttrr_pkg::FN_FINDZ:
                for (int i = 0; i < 64; i++)
                    if (parent_tab[i] == s && status_tab[i] == ttrr_pkg::ST_ZOMBIE)
                    begin
                        r = hit(i, 1);
                        break;
                    end
            ttrr_pkg::FN_SCHEDULE:
            begin
                idx = cur;
                for (int k = 0; k < 64; k++)
                begin
                    idx = (idx + 1) % 64;
                    if (status_tab[idx] == ttrr_pkg::ST_READY)
                    begin
                        status_tab[idx] = ttrr_pkg::ST_RUNNING;
                        cur = idx[5:0];
                        r = hit(idx, 0);
                        break;
                    end
                end
            end
            ttrr_pkg::FN_RUN:
            begin
                status_tab[s] = ttrr_pkg::ST_RUNNING;
                cur = s[5:0];
                r = hit(s, 0);
            end
            default: r = '0;
        endcase
        pending_q.push_back(r);
    endfunction

    function void check_result(ttrr_pkg::out_item_t got);
        ttrr_pkg::out_item_t want;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got.ok !== want.ok)
        begin
            $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
            errors++;
        end
        if (got.result_slot !== want.result_slot)
        begin
            $display("%0t: slot expected %0d actual %0d", $time, want.result_slot,
                     got.result_slot);
            errors++;
        end
        if (got.result_pid !== want.result_pid)
        begin
            $display("%0t: pid expected %0d actual %0d", $time, want.result_pid,
                     got.result_pid);
            errors++;
        end
        if (got.result_exit !== want.result_exit)
        begin
            $display("%0t: exit expected %0d actual %0d", $time, want.result_exit,
                     got.result_exit);
            errors++;
        end
        if (got.result_status !== want.result_status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.result_status,
                     got.result_status);
            errors++;
        end
    endfunction
endclass

module tb_task_table_round_robin_scheduler;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    ttrr_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    ttrr_pkg::out_item_t out_data;
    bit stim_done = 0;
    task_scoreboard board = new();

    task_table_round_robin_scheduler i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    task automatic send_op(ttrr_pkg::func_t f, int s, logic [31:0] ev);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {f, s[5:0], ev};
        do
            @(posedge clk);
        while (in_stall);
        board.note_transfer(in_data);
    endtask

    task automatic send_raw(logic [3:0] f, int s, logic [31:0] ev);
        send_op(ttrr_pkg::func_t'(f), s, ev);
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    initial
    begin
        int burst;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
                burst--;
            else if ($urandom_range(9) < 4)
            begin
                out_stall <= 1'b0;
                burst = $urandom_range(40, 1);
            end
            else
                out_stall <= (gap_len() != 0);
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [3:0] pick_func();
        int p;
        p = $urandom_range(99);
        if (p < 14) return ttrr_pkg::FN_ALLOC;
        if (p < 22) return ttrr_pkg::FN_FREE;
        if (p < 36) return ttrr_pkg::FN_READY;
        if (p < 42) return ttrr_pkg::FN_YIELD;
        if (p < 47) return ttrr_pkg::FN_BLOCK;
        if (p < 60) return ttrr_pkg::FN_LINK;
        if (p < 70) return ttrr_pkg::FN_EXIT;
        if (p < 80) return ttrr_pkg::FN_FINDZ;
        if (p < 93) return ttrr_pkg::FN_SCHEDULE;
        if (p < 97) return ttrr_pkg::FN_RUN;
        return 4'($urandom_range(15, 10));
    endfunction

    initial
    begin
        int s;
        logic [3:0] f;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_op(ttrr_pkg::FN_SCHEDULE, 0, 0);
        send_op(ttrr_pkg::FN_FINDZ, 0, 0);
        send_op(ttrr_pkg::FN_FREE, 0, 0);
        send_op(ttrr_pkg::FN_ALLOC, 0, 0);
        send_op(ttrr_pkg::FN_ALLOC, 63, 0);
        send_op(ttrr_pkg::FN_LINK, 1, 0);
        send_op(ttrr_pkg::FN_LINK, 2, 0);
        send_op(ttrr_pkg::FN_EXIT, 1, 32'h8000_0000);
        send_op(ttrr_pkg::FN_EXIT, 2, 32'h7fff_ffff);
        send_op(ttrr_pkg::FN_FINDZ, 0, 0);
        send_op(ttrr_pkg::FN_READY, 63, 0);
        send_op(ttrr_pkg::FN_YIELD, 17, 0);
        send_op(ttrr_pkg::FN_SCHEDULE, 5, 0);
        send_op(ttrr_pkg::FN_BLOCK, 0, 0);
        send_op(ttrr_pkg::FN_RUN, 0, 0);
        send_op(ttrr_pkg::FN_FREE, 63, 0);
        send_raw(4'd10, 3, 0);
        send_raw(4'd15, 63, 32'hffff_ffff);
        for (int i = 0; i < 66; i++)
            send_op(ttrr_pkg::FN_ALLOC, 0, 0);
        drain();
        for (int i = 0; i < 300; i++)
            send_op(ttrr_pkg::FN_LINK, 5, 0);
        send_op(ttrr_pkg::FN_EXIT, 0, 32'hffff_ffff);
        send_op(ttrr_pkg::FN_FINDZ, 0, 0);
        for (int i = 0; i < 1464; i++)
        begin
            f = pick_func();
            s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
            send_raw(f, s, $urandom());
        end
        drain();
        repeat (200) @(posedge clk);
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        drain();
        repeat (150) @(posedge clk);
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("tb: failure");
        $finish;
    end
endmodule
